// ===== hw/rtl/ptsb_pkg.sv =====
// shared types and constants for the periodic timer slot bank
// no dependencies; imported by ptsb_divider, periodic_timer_slot_bank and tb

package ptsb_pkg;

    localparam int MODE_W       = 4;
    localparam int SLOT_FIELD_W = 3;
    localparam int VALUE_W      = 16;
    localparam int STATUS_W     = 2;
    localparam int MASK_W       = 8;
    localparam int IN_USE_W     = 4;
    localparam int TICK_RATE_W  = 20;

    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 20'd1000;

    // one quotient bit per step over the tick rate word
    localparam int DIV_STEPS = TICK_RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK      = 4'd0,
        MODE_ADD       = 4'd1,
        MODE_SET_FREQ  = 4'd2,
        MODE_RESUME    = 4'd3,
        MODE_RESTART   = 4'd4,
        MODE_RESTART_NOW = 4'd5,
        MODE_STOP      = 4'd6,
        MODE_POLL      = 4'd7,
        MODE_CLEAR_ALL = 4'd8
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE        = 2'd0,
        STAT_NO_FREE     = 2'd1,
        STAT_NOT_IN_USE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/ptsb_divider.sv =====
// serial restoring divider: tick rate over frequency, one quotient bit a cycle
// depends on ptsb_pkg; the quotient saturates to 16 bits (divide by zero gives all ones)

module ptsb_divider
    import ptsb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [TICK_RATE_W-1:0] dividend,
    input  logic [VALUE_W-1:0]     divisor,
    output logic                   done,
    output logic [VALUE_W-1:0]     quotient
);

    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [VALUE_W-1:0]     rem_reg;
    logic [TICK_RATE_W-1:0] quo_reg;

    logic [VALUE_W:0]       shifted;
    logic [VALUE_W+1:0]     diff;
    logic                   ge;

    // shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[TICK_RATE_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};
    assign ge      = ~diff[VALUE_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
            quo_reg <= {quo_reg[TICK_RATE_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = (|quo_reg[TICK_RATE_W-1:VALUE_W]) ? {VALUE_W{1'b1}}
                                                         : quo_reg[VALUE_W-1:0];

endmodule

// ===== hw/rtl/periodic_timer_slot_bank.sv =====
// periodic timer slot bank top level: command sequencer, slot state, result register
// depends on ptsb_pkg and ptsb_divider
//
// usage
//   s_ channel carries one command item (mode, slot, value); m_ channel returns one
//   result item per command (status, assigned slot, fired mask, slots in use).
//   cfg channel writes tick_rate, the dividend for frequency to period conversion;
//   cfg_ready is always high, writes are meant for when the block is idle.
// timing
//   a command is taken in idle, decoded in the exec state, and its result is loaded
//   into the output register from the output state once that register is free. tick
//   and add walk the slots one per cycle through the shared decrement/compare path.
//   set frequency on a claimed slot runs the serial divider, 20 steps. one item is in
//   flight at a time.
// reset
//   aresetn is synchronous, active low: all slots unclaimed, stopped and not fired,
//   claimed count zero, tick_rate 1000, no result pending. no clearing pass.
// stall
//   while m_ready is low a finished result sits in the output register; the next
//   command may be taken and worked, and its own result waits in the sequencer
//   until the output register frees up.

module periodic_timer_slot_bank
    import ptsb_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [TICK_RATE_W-1:0]  cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MODE_W-1:0]       s_mode,
    input  logic [SLOT_FIELD_W-1:0] s_slot,
    input  logic [VALUE_W-1:0]      s_value,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic [SLOT_FIELD_W-1:0] m_assigned_slot,
    output logic [MASK_W-1:0]       m_fired_mask,
    output logic [IN_USE_W-1:0]     m_slots_in_use
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [5:0] SLOTS_LIM = 6'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

    // sequencer
    state_t state_reg, state_next;

    // latched command
    logic [MODE_W-1:0]       mode_reg;
    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [VALUE_W-1:0]      value_reg;

    // slot state
    logic [VALUE_W-1:0] cd_reg [SLOTS];
    logic [VALUE_W-1:0] rl_reg [SLOTS];
    logic [SLOTS-1:0]   running_reg;
    logic [SLOTS-1:0]   fired_reg;
    logic [SLOTS-1:0]   claimed_reg;
    logic [CNT_W-1:0]   claimed_count_reg;

    logic [TICK_RATE_W-1:0] tick_rate_reg;
    logic [SLOT_W-1:0]      idx_reg;

    // pending result of the command in flight
    status_t                 res_status_reg;
    logic [SLOT_FIELD_W-1:0] res_slot_reg;
    logic [MASK_W-1:0]       res_mask_reg;

    // output register
    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [SLOT_FIELD_W-1:0] m_slot_reg;
    logic [MASK_W-1:0]       m_mask_reg;
    logic [IN_USE_W-1:0]     m_in_use_reg;

    mode_t             cmd;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_in_use;
    logic [SLOT_W-1:0] acc_idx;
    logic [VALUE_W-1:0] cd_rd;
    logic [VALUE_W-1:0] rl_rd;
    logic [VALUE_W-1:0] cd_dec;
    logic              walk_last;
    logic [MASK_W-1:0] poll_mask;
    logic [IN_USE_W-1:0] in_use_sat;

    logic              div_start;
    logic              div_done;
    logic [VALUE_W-1:0] div_quotient;
    logic              out_load;
    logic              in_accept;

    assign cmd         = mode_t'(mode_reg);
    assign slot_idx    = SLOT_W'(slot_reg);
    assign slot_in_use = ({3'b000, slot_reg} < SLOTS_LIM) && claimed_reg[slot_idx];
    assign walk_last   = (idx_reg == LAST_IDX);
    assign in_accept   = s_valid && s_ready;

    // one read/write address into the slot arrays: walk index or addressed slot
    assign acc_idx = (state_reg == ST_WALK) ? idx_reg : slot_idx;
    assign cd_rd   = cd_reg[acc_idx];
    assign rl_rd   = rl_reg[acc_idx];
    assign cd_dec  = cd_rd - 1'b1;

    // only the first eight slots are reported
    always_comb begin
        poll_mask = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < SLOTS) begin
                poll_mask[i] = fired_reg[i];
            end
        end
    end

    assign in_use_sat = (32'(claimed_count_reg) > 32'd15) ? 4'd15
                                                           : IN_USE_W'(claimed_count_reg);

    ptsb_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tick_rate_reg),
        .divisor  (value_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (cmd == MODE_TICK || cmd == MODE_ADD) begin
                    state_next = ST_WALK;
                end else if (cmd == MODE_SET_FREQ && slot_in_use) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_WALK: begin
                if (walk_last || (cmd == MODE_ADD && !claimed_reg[idx_reg])) begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: div_start = (cmd == MODE_SET_FREQ) && slot_in_use;
            ST_OUT:  out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command latch
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            mode_reg  <= s_mode;
            slot_reg  <= s_slot;
            value_reg <= s_value;
        end
    end

    // tick rate register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_rate_reg <= TICK_RATE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tick_rate_reg <= cfg_data;
        end
    end

    // slot flags, claimed count, walk index and pending result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg       <= '0;
            fired_reg         <= '0;
            claimed_reg       <= '0;
            claimed_count_reg <= '0;
            idx_reg           <= '0;
            res_status_reg    <= STAT_DONE;
            res_slot_reg      <= '0;
            res_mask_reg      <= '0;
        end else begin
            unique case (state_reg)
                ST_EXEC: begin
                    idx_reg        <= '0;
                    res_status_reg <= STAT_DONE;
                    res_slot_reg   <= '0;
                    res_mask_reg   <= '0;
                    unique case (cmd)
                        MODE_TICK, MODE_ADD: ;
                        MODE_SET_FREQ: begin
                            if (!slot_in_use) begin
                                res_status_reg <= STAT_NOT_IN_USE;
                            end
                        end
                        MODE_RESUME, MODE_RESTART, MODE_RESTART_NOW: begin
                            if (slot_in_use) begin
                                running_reg[slot_idx] <= 1'b1;
                            end else begin
                                res_status_reg <= STAT_NOT_IN_USE;
                            end
                        end
                        MODE_STOP: begin
                            if (slot_in_use) begin
                                running_reg[slot_idx] <= 1'b0;
                                fired_reg[slot_idx]   <= 1'b0;
                            end else begin
                                res_status_reg <= STAT_NOT_IN_USE;
                            end
                        end
                        MODE_POLL: begin
                            res_mask_reg <= poll_mask;
                            fired_reg    <= '0;
                        end
                        MODE_CLEAR_ALL: begin
                            running_reg       <= '0;
                            fired_reg         <= '0;
                            claimed_reg       <= '0;
                            claimed_count_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_WALK: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (cmd == MODE_TICK) begin
                        // countdown hit zero after the decrement: reload and fire
                        if (running_reg[idx_reg] && cd_dec == '0) begin
                            fired_reg[idx_reg] <= 1'b1;
                        end
                    end else begin
                        // lowest free slot wins
                        if (!claimed_reg[idx_reg]) begin
                            claimed_reg[idx_reg] <= 1'b1;
                            running_reg[idx_reg] <= 1'b1;
                            fired_reg[idx_reg]   <= 1'b0;
                            claimed_count_reg    <= claimed_count_reg + 1'b1;
                            res_slot_reg         <= SLOT_FIELD_W'(idx_reg);
                        end else if (walk_last) begin
                            res_status_reg <= STAT_NO_FREE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // countdown and reload words; only read for claimed slots, which add writes first
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_EXEC: begin
                if (slot_in_use) begin
                    if (cmd == MODE_RESTART) begin
                        cd_reg[acc_idx] <= rl_rd;
                    end else if (cmd == MODE_RESTART_NOW) begin
                        cd_reg[acc_idx] <= VALUE_W'(1);
                    end
                end
            end
            ST_WALK: begin
                if (cmd == MODE_TICK) begin
                    if (running_reg[idx_reg]) begin
                        cd_reg[acc_idx] <= (cd_dec == '0) ? rl_rd : cd_dec;
                    end
                end else if (!claimed_reg[idx_reg]) begin
                    cd_reg[acc_idx] <= value_reg;
                    rl_reg[acc_idx] <= value_reg;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    cd_reg[acc_idx] <= div_quotient;
                    rl_reg[acc_idx] <= div_quotient;
                end
            end
            default: ;
        endcase
    end

    // output register, parts the sequencer from a stalled receiver
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_mask_reg   <= res_mask_reg;
            m_in_use_reg <= in_use_sat;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_assigned_slot = m_slot_reg;
    assign m_fired_mask    = m_mask_reg;
    assign m_slots_in_use  = m_in_use_reg;

    // claimed count tracks the claimed flags
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(claimed_count_reg) == $countones(claimed_reg))
        else $error("claimed count out of step with claimed flags");

    // a slot that is not claimed can neither run nor fire
    a_flags_claimed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((running_reg | fired_reg) & ~claimed_reg) == '0)
        else $error("running or fired flag on an unclaimed slot");

    // the divider only finishes while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    // a new result only appears from the output state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside the output state");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for periodic_timer_slot_bank: directed and random command items
// checks every result against a behavioral model of the slot bank kept in this file
// depends on ptsb_pkg and periodic_timer_slot_bank

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptsb_pkg::*;

    localparam int SLOT_COUNT       = 8;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int NUM_PHASES       = 5;
    localparam int SETTLE_CYCLES    = 40;     // longer than a set frequency command
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int HOLD_AFTER       = 60;     // results taken before the long hold
    localparam int HOLD_CYCLES      = 300;
    localparam int PATTERN_SPAN     = 48;

    localparam logic [MODE_W-1:0]      MODE_UNUSED_FIRST = 4'd9;
    localparam logic [MODE_W-1:0]      MODE_UNUSED_LAST  = 4'd15;
    localparam logic [VALUE_W-1:0]     PERIOD_MAX        = 16'hFFFF;
    localparam logic [TICK_RATE_W-1:0] TICK_RATE_MAX     = 20'd1000000;
    localparam logic [TICK_RATE_W-1:0] TICK_RATE_MIN     = 20'd1;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [VALUE_W-1:0]      value;
    } timer_cmd_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_FIELD_W-1:0] assigned_slot;
        logic [MASK_W-1:0]       fired_mask;
        logic [IN_USE_W-1:0]     slots_in_use;
    } timer_result_t;

    // clock, reset and block ports, the driven inputs all known from time zero
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [TICK_RATE_W-1:0]  cfg_data  = TICK_RATE_RESET;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode    = '0;
    logic [SLOT_FIELD_W-1:0] s_slot    = '0;
    logic [VALUE_W-1:0]      s_value   = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic [STATUS_W-1:0]     m_status;
    logic [SLOT_FIELD_W-1:0] m_assigned_slot;
    logic [MASK_W-1:0]       m_fired_mask;
    logic [IN_USE_W-1:0]     m_slots_in_use;

    // commands waiting to be offered, and results the model says are on their way
    timer_cmd_t    command_backlog[$];
    timer_result_t pending_results[$];

    // model copy of the slot bank
    logic [TICK_RATE_W-1:0] tick_rate_model = TICK_RATE_RESET;
    logic [VALUE_W-1:0]     slot_count  [SLOT_COUNT] = '{default: '0};
    logic [VALUE_W-1:0]     slot_reload [SLOT_COUNT] = '{default: '0};
    logic                   slot_running[SLOT_COUNT] = '{default: 1'b0};
    logic                   slot_fired  [SLOT_COUNT] = '{default: 1'b0};
    logic                   slot_claimed[SLOT_COUNT] = '{default: 1'b0};
    int unsigned            claimed_total = 0;

    // bookkeeping
    int failures         = 0;
    int commands_taken   = 0;
    int results_checked  = 0;
    int fired_reported   = 0;
    int full_bank_adds   = 0;
    int unclaimed_hits   = 0;
    int burst_left       = 0;
    int gap_left         = 0;
    int quiet_cycles     = 0;

    periodic_timer_slot_bank #(
        .SLOTS(SLOT_COUNT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_slot         (s_slot),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_assigned_slot(m_assigned_slot),
        .m_fired_mask   (m_fired_mask),
        .m_slots_in_use (m_slots_in_use)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // advance the model by one accepted command and queue the result it implies
    task automatic apply_command(input timer_cmd_t c);
        timer_result_t r;
        logic [31:0]   quotient;
        int            i;
        r = '{status: STAT_DONE, assigned_slot: '0, fired_mask: '0, slots_in_use: '0};
        case (c.mode)
            MODE_TICK: begin
                // every running slot counts down, wrapping, and reloads on reaching zero
                for (i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_running[i]) begin
                        slot_count[i] = slot_count[i] - 1'b1;
                        if (slot_count[i] == '0) begin
                            slot_count[i] = slot_reload[i];
                            slot_fired[i] = 1'b1;
                        end
                    end
                end
            end
            MODE_ADD: begin
                // lowest free slot wins; a full bank reports no free slot and changes nothing
                r.status = STAT_NO_FREE;
                for (i = 0; i < SLOT_COUNT; i++) begin
                    if (!slot_claimed[i] && r.status == STAT_NO_FREE) begin
                        slot_claimed[i] = 1'b1;
                        slot_running[i] = 1'b1;
                        slot_fired[i]   = 1'b0;
                        slot_reload[i]  = c.value;
                        slot_count[i]   = c.value;
                        claimed_total++;
                        r.assigned_slot = i[SLOT_FIELD_W-1:0];
                        r.status        = STAT_DONE;
                    end
                end
                if (r.status == STAT_NO_FREE) begin
                    full_bank_adds++;
                end
            end
            MODE_SET_FREQ, MODE_RESUME, MODE_RESTART, MODE_RESTART_NOW, MODE_STOP: begin
                if (!slot_claimed[c.slot]) begin
                    r.status = STAT_NOT_IN_USE;
                    unclaimed_hits++;
                end else begin
                    case (c.mode)
                        MODE_SET_FREQ: begin
                            // zero frequency or an oversize quotient saturates the period
                            if (c.value == '0) begin
                                slot_reload[c.slot] = PERIOD_MAX;
                            end else begin
                                quotient = 32'(tick_rate_model) / 32'(c.value);
                                slot_reload[c.slot] = (quotient > PERIOD_MAX) ?
                                                      PERIOD_MAX : quotient[VALUE_W-1:0];
                            end
                            slot_count[c.slot] = slot_reload[c.slot];
                        end
                        MODE_RESUME: begin
                            slot_running[c.slot] = 1'b1;
                        end
                        MODE_RESTART: begin
                            slot_running[c.slot] = 1'b1;
                            slot_count[c.slot]   = slot_reload[c.slot];
                        end
                        MODE_RESTART_NOW: begin
                            slot_running[c.slot] = 1'b1;
                            slot_count[c.slot]   = 16'd1;
                        end
                        default: begin
                            // stop keeps the slot claimed
                            slot_running[c.slot] = 1'b0;
                            slot_fired[c.slot]   = 1'b0;
                        end
                    endcase
                end
            end
            MODE_POLL: begin
                for (i = 0; i < SLOT_COUNT; i++) begin
                    r.fired_mask[i] = slot_fired[i];
                    slot_fired[i]   = 1'b0;
                end
            end
            MODE_CLEAR_ALL: begin
                for (i = 0; i < SLOT_COUNT; i++) begin
                    slot_count[i]   = '0;
                    slot_reload[i]  = '0;
                    slot_running[i] = 1'b0;
                    slot_fired[i]   = 1'b0;
                    slot_claimed[i] = 1'b0;
                end
                claimed_total = 0;
            end
            default: begin
                // unused modes do nothing and report done
            end
        endcase
        r.slots_in_use = (claimed_total > 15) ? 4'd15 : claimed_total[IN_USE_W-1:0];
        pending_results.push_back(r);
    endtask

    function automatic void queue_command(input logic [MODE_W-1:0] mode,
                                          input logic [SLOT_FIELD_W-1:0] slot,
                                          input logic [VALUE_W-1:0] value);
        command_backlog.push_back('{mode: mode, slot: slot, value: value});
    endfunction

    // command driver: bursts of back-to-back items separated by random gaps;
    // valid is computed once per edge so it never drops and rises in one step
    always @(posedge aclk) begin : drive_commands
        logic       next_valid;
        timer_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                apply_command('{mode: s_mode, slot: s_slot, value: s_value});
                commands_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (command_backlog.size() > 0) begin
                    c = command_backlog.pop_front();
                    s_mode  <= c.mode;
                    s_slot  <= c.slot;
                    s_value <= c.value;
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // half the bursts run straight into the next one
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // result receiver: a rotating stall pattern reloaded when its span runs out, all-ready
    // about a third of the time, plus one long hold to back up the input
    always @(posedge aclk) begin : stall_results
        logic [15:0] stall_pattern;
        int          pattern_left;
        int          hold_left;
        int          taken;
        bit          hold_done;
        if (!aresetn) begin
            m_ready       <= 1'b0;
            stall_pattern = '1;
            pattern_left  = 0;
            hold_left     = 0;
            taken         = 0;
            hold_done     = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                taken++;
            end
            if (!hold_done && taken >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (pattern_left == 0) begin
                pattern_left  = PATTERN_SPAN;
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            end else begin
                pattern_left--;
            end
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= stall_pattern[0];
            end
        end
    end

    // result checker: oldest expectation against each accepted result item
    always @(posedge aclk) begin : check_results
        timer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no command outstanding");
                failures++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                fired_reported += $countones(m_fired_mask);
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failures++;
                end
                if (m_assigned_slot !== want.assigned_slot) begin
                    $error("assigned_slot: expected %0d, got %0d",
                           want.assigned_slot, m_assigned_slot);
                    failures++;
                end
                if (m_fired_mask !== want.fired_mask) begin
                    $error("fired_mask: expected %02h, got %02h", want.fired_mask, m_fired_mask);
                    failures++;
                end
                if (m_slots_in_use !== want.slots_in_use) begin
                    $error("slots_in_use: expected %0d, got %0d",
                           want.slots_in_use, m_slots_in_use);
                    failures++;
                end
            end
        end
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no handshake for %0d cycles, %0d results outstanding",
                       quiet_cycles, pending_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // phases: reset tick rate with directed items first, then one tick rate per phase,
    // written only once the bank has gone quiet
    initial begin : run_phases
        logic [TICK_RATE_W-1:0] rate;
        timer_cmd_t             c;
        int                     phase;
        int                     n;
        int                     pick;
        int                     k;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty poll, unclaimed slot, fill the bank with edge periods, overflow
        queue_command(MODE_POLL, 3'd0, 16'd0);
        queue_command(MODE_STOP, 3'd3, 16'd0);
        queue_command(MODE_ADD, 3'd0, 16'd1);
        queue_command(MODE_ADD, 3'd0, 16'd0);          // wraps to a 65536 tick period
        queue_command(MODE_ADD, 3'd0, 16'hFFFF);
        queue_command(MODE_ADD, 3'd0, 16'd2);
        queue_command(MODE_ADD, 3'd0, 16'd3);
        queue_command(MODE_ADD, 3'd0, 16'd1);
        queue_command(MODE_ADD, 3'd0, 16'd2);
        queue_command(MODE_ADD, 3'd0, 16'h5555);
        queue_command(MODE_ADD, 3'd7, 16'hAAAA);       // bank is full here
        queue_command(MODE_TICK, 3'd0, 16'd0);
        queue_command(MODE_TICK, 3'd0, 16'd0);
        queue_command(MODE_POLL, 3'd0, 16'd0);
        queue_command(MODE_SET_FREQ, 3'd2, 16'd0);     // zero frequency saturates
        queue_command(MODE_SET_FREQ, 3'd3, 16'd1);
        queue_command(MODE_SET_FREQ, 3'd4, 16'd2000);  // tick rate below frequency
        queue_command(MODE_RESTART_NOW, 3'd1, 16'd0);
        queue_command(MODE_STOP, 3'd0, 16'd0);
        queue_command(MODE_RESUME, 3'd0, 16'd0);
        queue_command(MODE_RESTART, 3'd3, 16'd0);
        queue_command(MODE_TICK, 3'd0, 16'd0);
        queue_command(MODE_POLL, 3'd0, 16'd0);
        queue_command(MODE_UNUSED_LAST, 3'd7, 16'hFFFF);
        queue_command(MODE_CLEAR_ALL, 3'd0, 16'd0);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1:       rate = TICK_RATE_MIN;
                    2:       rate = TICK_RATE_MAX;
                    3:       rate = 20'h7FFFF;
                    default: rate = TICK_RATE_W'($urandom_range(2, TICK_RATE_MAX - 1));
                endcase
                @(posedge aclk);
                cfg_valid <= 1'b1;
                cfg_data  <= rate;
                do @(posedge aclk); while (!cfg_ready);
                tick_rate_model = rate;
                cfg_valid <= 1'b0;
            end

            // random mix weighted toward ticks and polls so slots really fire
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick    = $urandom_range(0, 99);
                c.slot  = SLOT_FIELD_W'($urandom_range(0, SLOT_COUNT - 1));
                c.value = VALUE_W'($urandom_range(0, 16'hFFFF));
                if (pick < 34) begin
                    c.mode = MODE_TICK;
                end else if (pick < 46) begin
                    c.mode = MODE_ADD;
                    k = $urandom_range(0, 9);
                    if (k < 6) begin
                        c.value = VALUE_W'($urandom_range(1, 6));
                    end else if (k == 6) begin
                        c.value = '0;
                    end else if (k == 7) begin
                        c.value = PERIOD_MAX;
                    end
                end else if (pick < 54) begin
                    c.mode = MODE_SET_FREQ;
                    k = $urandom_range(0, 9);
                    if (k == 0) begin
                        c.value = '0;
                    end else if (k < 4) begin
                        c.value = VALUE_W'($urandom_range(1, 8));
                    end else if (k < 7 && tick_rate_model / 6 <= PERIOD_MAX) begin
                        // frequency near the tick rate gives a short period
                        c.value = VALUE_W'(tick_rate_model / $urandom_range(1, 6));
                    end
                end else if (pick < 60) begin
                    c.mode = MODE_RESUME;
                end else if (pick < 66) begin
                    c.mode = MODE_RESTART;
                end else if (pick < 74) begin
                    c.mode = MODE_RESTART_NOW;
                end else if (pick < 80) begin
                    c.mode = MODE_STOP;
                end else if (pick < 93) begin
                    c.mode = MODE_POLL;
                end else if (pick < 96) begin
                    c.mode = MODE_CLEAR_ALL;
                end else begin
                    c.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
                end
                command_backlog.push_back(c);
            end

            // drain the phase before touching the tick rate again; sampled between
            // edges so an item just taken from the backlog already shows as valid
            while (command_backlog.size() != 0 || s_valid || pending_results.size() != 0) begin
                @(negedge aclk);
            end
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end

        $display("run covered %0d command items over %0d tick rate settings, %0d results checked",
                 commands_taken, NUM_PHASES, results_checked);
        $display("fired flags reported %0d, full bank adds %0d, unclaimed slot commands %0d",
                 fired_reported, full_bank_adds, unclaimed_hits);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
